/* hdl/wlc_pkg.sv */
`timescale 1ns / 1ps

package wlc_pkg;

  // Field and state widths.
  localparam int LEVEL_W    = 4;
  localparam int BAR_W      = 10;
  localparam int MODE_W     = 3;
  localparam int PRESS_W    = 16;
  localparam int PINCH_W    = 8;
  localparam int DELAY_W    = 17;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MS       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PINCH_TICKS   = 3'd4;

  // Mode codes of the waiting modes as they appear on mode_now.
  localparam logic [MODE_W-1:0] MODE_CODE_UPM   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CODE_DNM   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_CODE_PINCH = 3'd7;

  // Register values after reset.
  localparam logic [7:0]  DEBOUNCE_RST   = 8'd10;
  localparam logic [15:0] LONG_PRESS_RST = 16'd500;
  localparam logic [15:0] STEP_RST       = 16'd400;
  localparam logic [15:0] LOCKOUT_RST    = 16'd5000;
  localparam logic [7:0]  PINCH_RST      = 8'd20;

  typedef struct packed {
    logic [7:0]  debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] step_ms;
    logic [15:0] lockout_ms;
    logic [7:0]  pinch_ticks;
  } wlc_cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] window_level;
    logic [BAR_W-1:0]   level_bar;
    logic               up_lamp;
    logic               down_lamp;
    logic [MODE_W-1:0]  mode_now;
    logic               busy_res;
  } wlc_res_t;

endpackage

/* hdl/wlc_if.sv */
`timescale 1ns / 1ps

// Input channel: one tick of button and sensor levels per item.
interface wlc_in_if;
  logic valid;
  logic ready;
  logic up_pressed;
  logic down_pressed;
  logic pinch_sensed;

  modport source (output valid, up_pressed, down_pressed, pinch_sensed, input ready);
  modport sink   (input valid, up_pressed, down_pressed, pinch_sensed, output ready);
endinterface

// Result channel: controller outputs after each tick.
interface wlc_out_if;
  logic                         valid;
  logic                         ready;
  logic [wlc_pkg::LEVEL_W-1:0]  window_level;
  logic [wlc_pkg::BAR_W-1:0]    level_bar;
  logic                         up_lamp;
  logic                         down_lamp;
  logic [wlc_pkg::MODE_W-1:0]   mode_now;
  logic                         busy_res;

  modport source (output valid, window_level, level_bar, up_lamp, down_lamp, mode_now,
                  busy_res, input ready);
  modport sink   (input valid, window_level, level_bar, up_lamp, down_lamp, mode_now,
                  busy_res, output ready);
endinterface

/* hdl/wlc_cfg.sv */
`timescale 1ns / 1ps

module wlc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [wlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output wlc_pkg::wlc_cfg_t              cfg
);
  import wlc_pkg::*;

  wlc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms   <= DEBOUNCE_RST;
      cfg_r.long_press_ms <= LONG_PRESS_RST;
      cfg_r.step_ms       <= STEP_RST;
      cfg_r.lockout_ms    <= LOCKOUT_RST;
      cfg_r.pinch_ticks   <= PINCH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_MS:   cfg_r.debounce_ms   <= cfg_wdata[7:0];
        CFG_LONG_PRESS_MS: cfg_r.long_press_ms <= cfg_wdata;
        CFG_STEP_MS:       cfg_r.step_ms       <= cfg_wdata;
        CFG_LOCKOUT_MS:    cfg_r.lockout_ms    <= cfg_wdata;
        CFG_PINCH_TICKS:   cfg_r.pinch_ticks   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/wlc_core.sv */
`timescale 1ns / 1ps

module wlc_core #(
  parameter int LEVELS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              up,
  input  logic              down,
  input  logic              pinch,
  input  wlc_pkg::wlc_cfg_t cfg,
  output wlc_pkg::wlc_res_t res
);
  import wlc_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    M_IDLE  = 3'd0,
    M_UPD   = 3'd1,
    M_DND   = 3'd2,
    M_UPA   = 3'd3,
    M_DNA   = 3'd4,
    M_UPM   = 3'd5,
    M_DNM   = 3'd6,
    M_PINCH = 3'd7
  } mode_t;

  localparam logic [LEVEL_W-1:0] LVL_MAX = LEVEL_W'(LEVELS);

  mode_t              mode_r, mode_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [PRESS_W-1:0] press_r, press_nxt;
  logic               half_r, half_nxt;
  logic [PINCH_W-1:0] pcnt_r, pcnt_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [BAR_W-1:0]   bar_r, bar_nxt;
  logic [1:0]         lamps_r, lamps_nxt;

  function automatic logic [BAR_W-1:0] thermo(input logic [LEVEL_W-1:0] lvl);
    logic [BAR_W-1:0] b;
    for (int i = 0; i < BAR_W; i++) begin
      b[i] = (lvl > LEVEL_W'(i));
    end
    return b;
  endfunction

  function automatic logic [PRESS_W-1:0] sat_inc(input logic [PRESS_W-1:0] v);
    return (v == {PRESS_W{1'b1}}) ? v : v + PRESS_W'(1);
  endfunction

  function automatic logic [LEVEL_W-1:0] lvl_up(input logic [LEVEL_W-1:0] v);
    return (v < LVL_MAX) ? v + LEVEL_W'(1) : v;
  endfunction

  function automatic logic [LEVEL_W-1:0] lvl_dn(input logic [LEVEL_W-1:0] v);
    return (v != '0) ? v - LEVEL_W'(1) : v;
  endfunction

  always_comb begin
    logic btn;
    logic waiting;
    mode_nxt  = mode_r;
    level_nxt = level_r;
    press_nxt = press_r;
    half_nxt  = half_r;
    pcnt_nxt  = pcnt_r;
    delay_nxt = delay_r;
    bar_nxt   = bar_r;
    lamps_nxt = lamps_r;
    btn       = 1'b0;
    waiting   = 1'b0;

    if (in_fire) begin
      if (delay_r != '0) begin
        // A pending wait swallows the tick; its end finishes the waiting step.
        delay_nxt = delay_r - DELAY_W'(1);
        if (delay_nxt == '0) begin
          if (mode_r == M_UPM) begin
            lamps_nxt[0] = 1'b0;
            if (!up) mode_nxt = M_IDLE;
          end else if (mode_r == M_DNM) begin
            lamps_nxt[1] = 1'b0;
            if (!down) mode_nxt = M_IDLE;
          end else if (mode_r == M_PINCH && level_r == '0) begin
            mode_nxt = M_IDLE;
          end
        end
      end else begin
        half_nxt = ~half_r;
        if (half_r) begin
          unique case (mode_r)
            M_IDLE: begin
              lamps_nxt = 2'b00;
              bar_nxt   = thermo(level_r);
              if (up) begin
                press_nxt = sat_inc(press_nxt);
                if (press_nxt > PRESS_W'(cfg.debounce_ms)) mode_nxt = M_UPD;
              end
              if (down) begin
                press_nxt = sat_inc(press_nxt);
                if (press_nxt > PRESS_W'(cfg.debounce_ms)) mode_nxt = M_DND;
              end
            end
            M_UPD, M_DND: begin
              btn = (mode_r == M_UPD) ? up : down;
              if (btn) press_nxt = sat_inc(press_r);
              if (!btn && press_nxt < cfg.long_press_ms) begin
                if (mode_r == M_UPD) begin
                  mode_nxt  = M_UPA;
                  level_nxt = lvl_up(level_r);
                end else begin
                  mode_nxt  = M_DNA;
                  level_nxt = lvl_dn(level_r);
                end
                press_nxt = '0;
              end else if (btn && press_nxt > cfg.long_press_ms) begin
                mode_nxt = (mode_r == M_UPD) ? M_UPM : M_DNM;
              end
            end
            M_UPA: begin
              if (level_r >= LVL_MAX) begin
                press_nxt = '0;
                mode_nxt  = M_IDLE;
              end else begin
                lamps_nxt[0] = 1'b1;
                press_nxt    = sat_inc(press_r);
                bar_nxt      = thermo(level_r);
                if (press_nxt > cfg.step_ms) begin
                  level_nxt = lvl_up(level_r);
                  press_nxt = '0;
                end
              end
            end
            M_DNA: begin
              if (level_r == '0) begin
                press_nxt = '0;
                mode_nxt  = M_IDLE;
              end else begin
                lamps_nxt[1] = 1'b1;
                press_nxt    = sat_inc(press_r);
                bar_nxt      = thermo(level_r);
                if (press_nxt > cfg.step_ms) begin
                  level_nxt = lvl_dn(level_r);
                  press_nxt = '0;
                end
              end
            end
            M_UPM, M_DNM: begin
              if (mode_r == M_UPM && level_r < LVL_MAX) begin
                lamps_nxt[0] = 1'b1;
                level_nxt    = lvl_up(level_r);
                bar_nxt      = thermo(level_nxt);
                press_nxt    = '0;
                delay_nxt    = {cfg.step_ms, 1'b0};
                waiting      = (cfg.step_ms != '0);
              end else if (mode_r == M_DNM && level_r != '0) begin
                lamps_nxt[1] = 1'b1;
                level_nxt    = lvl_dn(level_r);
                bar_nxt      = thermo(level_nxt);
                press_nxt    = '0;
                delay_nxt    = {cfg.step_ms, 1'b0};
                waiting      = (cfg.step_ms != '0);
              end
              if (!waiting) begin
                if (mode_r == M_UPM) begin
                  lamps_nxt[0] = 1'b0;
                  if (!up) mode_nxt = M_IDLE;
                end else begin
                  lamps_nxt[1] = 1'b0;
                  if (!down) mode_nxt = M_IDLE;
                end
              end
            end
            M_PINCH: begin
              lamps_nxt[0] = 1'b0;
              if (level_r == '0) begin
                press_nxt = '0;
                delay_nxt = {cfg.lockout_ms, 1'b0};
                if (cfg.lockout_ms == '0) mode_nxt = M_IDLE;
              end else begin
                lamps_nxt[1] = 1'b1;
                level_nxt    = lvl_dn(level_r);
                bar_nxt      = thermo(level_nxt);
                if (level_nxt != '0) delay_nxt = {cfg.step_ms, 1'b0};
              end
            end
            default: begin
            end
          endcase
        end
        // Pinch watch runs on every live tick, after the mode step.
        if (pinch && mode_nxt == M_UPA) begin
          if (pcnt_r != {PINCH_W{1'b1}}) pcnt_nxt = pcnt_r + PINCH_W'(1);
          if (pcnt_nxt > cfg.pinch_ticks) begin
            pcnt_nxt = '0;
            mode_nxt = M_PINCH;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      level_r <= LVL_MAX;
      press_r <= '0;
      half_r  <= 1'b0;
      pcnt_r  <= '0;
      delay_r <= '0;
      bar_r   <= '0;
      lamps_r <= 2'b00;
    end else begin
      mode_r  <= mode_nxt;
      level_r <= level_nxt;
      press_r <= press_nxt;
      half_r  <= half_nxt;
      pcnt_r  <= pcnt_nxt;
      delay_r <= delay_nxt;
      bar_r   <= bar_nxt;
      lamps_r <= lamps_nxt;
    end
  end

  // Result of the item being accepted, taken from the next-state values.
  assign res.window_level = level_nxt;
  assign res.level_bar    = bar_nxt;
  assign res.up_lamp      = lamps_nxt[0];
  assign res.down_lamp    = lamps_nxt[1];
  assign res.mode_now     = MODE_W'(mode_nxt);
  assign res.busy_res     = (delay_nxt != '0);

endmodule

/* hdl/wlc_obuf.sv */
`timescale 1ns / 1ps

module wlc_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wlc_pkg::wlc_res_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wlc_pkg::wlc_res_t out_data
);
  import wlc_pkg::*;

  logic     out_valid_r;
  logic     skid_valid_r;
  wlc_res_t out_data_r;
  wlc_res_t skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r) begin
        out_valid_r <= push;
      end else if (out_ready) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (push) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end
    if (out_valid_r && !out_ready && push) begin
      skid_data_r <= push_data;
    end
  end

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

endmodule

/* hdl/window_lifter_controller_top.sv */
`timescale 1ns / 1ps

// Window lifter controller with anti-pinch reversal. Each input item is one
// 500 us tick carrying the up button, the down button and the pinch sensor;
// each accepted item yields exactly one result item with the window level,
// the LED bar, both travel lamps, the mode code and the busy flag as they
// stand after that tick. The block takes one item per clock cycle: the whole
// mode step is combinational logic between the state registers, and the
// result goes into a two-entry output buffer, so input stalls only when both
// entries hold results that have not been taken. Configuration writes take
// effect at the next clock edge and should be made while the block is idle.

module window_lifter_controller_top #(
  parameter int LEVELS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wlc_in_if.sink                         in_ch,
  wlc_out_if.source                      out_ch,
  input  logic                           cfg_wr_en,
  input  logic [wlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wlc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wlc_pkg::*;

  wlc_cfg_t cfg;
  wlc_res_t core_res;
  wlc_res_t out_data;
  logic     in_fire;
  logic     push_ready;

  // An item is taken whenever the output buffer has a free entry.
  assign in_ch.ready = push_ready;
  assign in_fire     = in_ch.valid && push_ready;

  wlc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Mode machine, level, counters and the busy countdown.
  wlc_core #(
    .LEVELS (LEVELS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .up      (in_ch.up_pressed),
    .down    (in_ch.down_pressed),
    .pinch   (in_ch.pinch_sensed),
    .cfg     (cfg),
    .res     (core_res)
  );

  // Output register with a skid entry behind it.
  wlc_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_data  (core_res),
    .push_ready (push_ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_data   (out_data)
  );

  assign out_ch.window_level = out_data.window_level;
  assign out_ch.level_bar    = out_data.level_bar;
  assign out_ch.up_lamp      = out_data.up_lamp;
  assign out_ch.down_lamp    = out_data.down_lamp;
  assign out_ch.mode_now     = out_data.mode_now;
  assign out_ch.busy_res     = out_data.busy_res;

`ifndef SYNTHESIS
  // A countdown is only ever started by the manual modes or the reversal.
  a_busy_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.busy_res) |->
      (out_ch.mode_now == MODE_CODE_UPM || out_ch.mode_now == MODE_CODE_DNM ||
       out_ch.mode_now == MODE_CODE_PINCH))
    else $error("busy result outside a waiting mode");

  // The level never leaves its range.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.window_level <= LEVEL_W'(LEVELS)))
    else $error("window level above the top");

  // The LED bar is always a thermometer code.
  a_bar_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.level_bar & (out_ch.level_bar + BAR_W'(1))) == '0))
    else $error("level bar is not a thermometer code");

  // Input stalls only while the buffer holds a result.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result waiting");
`endif

endmodule
